// ----- sv/set_assoc_cache_tag_policy_defines.svh -----
// Assertion macros shared by the cache tag and policy engine.
// Every macro samples on i_clk; the checked module must have that clock and i_rst_n.
`ifndef SET_ASSOC_CACHE_TAG_POLICY_DEFINES_SVH
`define SET_ASSOC_CACHE_TAG_POLICY_DEFINES_SVH

`ifndef ASSERT_OFF

// Property checked outside reset.
`define SACT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Property checked during reset as well.
`define SACT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define SACT_ASSERT(lbl, prop, msg)
`define SACT_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ----- sv/sact_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sact_pkg;

    // Address split
    localparam int ADDR_BITS     = 32;
    localparam int BYTE_SEL_BITS = 4;
    localparam int SET_BITS      = 6;
    localparam int TAG_WIDTH     = ADDR_BITS - BYTE_SEL_BITS - SET_BITS;
    localparam int SETS          = 1 << SET_BITS;

    // Ways and replacement counters (way count is a power of two)
    localparam int WAYS         = 4;
    localparam int WAY_BITS     = $clog2(WAYS);
    localparam int OUT_WAY_BITS = 2;
    localparam int CNT_BITS     = 2;
    localparam int LFSR_BITS    = 16;

    localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};

    typedef logic [TAG_WIDTH-1:0] t_tag;
    typedef logic [SET_BITS-1:0]  t_set;
    typedef logic [WAY_BITS-1:0]  t_way;
    typedef logic [CNT_BITS-1:0]  t_cnt;

    typedef enum logic [1:0] {
        POL_LRU  = 2'd0,
        POL_FIFO = 2'd1,
        POL_RAND = 2'd2,
        POL_LFU  = 2'd3
    } t_policy;

    // One way of a set as held in the tag memory
    typedef struct packed {
        logic valid;
        logic dirty;
        t_cnt cnt;
        t_tag tag;
    } t_entry;

    localparam int ENTRY_BITS = $bits(t_entry);
    localparam int ROW_BITS   = WAYS * ENTRY_BITS;

    typedef t_entry [WAYS-1:0] t_row;

    // Results gathered over one pass through the ways
    typedef struct packed {
        logic hit;
        t_way hit_way;
        logic free;
        t_way free_way;
        logic zero;
        t_way zero_way;
        t_cnt min_cnt;
        t_way min_way;
    } t_scan;

    // Controls for the per-way update pass
    typedef struct packed {
        t_policy policy;
        logic    fill;
        logic    wr;
        t_tag    tag;
        t_way    way;
        t_cnt    tgt_cnt;
    } t_upd_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_LOAD,
        S_SCAN,
        S_PICK,
        S_TGT,
        S_APPLY,
        S_WR
    } t_state;

endpackage

`default_nettype wire

// ----- sv/sact_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface sact_in_if import sact_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 func;
    logic [ADDR_BITS-1:0] address;

    modport source (output valid, output func, output address, input ready);
    modport sink   (input valid, input func, input address, output ready);
endinterface

`default_nettype wire

// ----- sv/sact_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface sact_out_if import sact_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    hit;
    logic [OUT_WAY_BITS-1:0] way;
    logic                    writeback;
    logic [ADDR_BITS-1:0]    evict_address;
    logic [ADDR_BITS-1:0]    fill_address;

    modport source (output valid, output hit, output way, output writeback,
                    output evict_address, output fill_address, input ready);
    modport sink   (input valid, input hit, input way, input writeback,
                    input evict_address, input fill_address, output ready);
endinterface

`default_nettype wire

// ----- sv/sact_cfg_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface sact_cfg_if ();
    logic       valid;
    logic       ready;
    logic [1:0] policy;

    modport source (output valid, output policy, input ready);
    modport sink   (input valid, input policy, output ready);
endinterface

`default_nettype wire

// ----- sv/sact_tag_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM, registered read
module sact_tag_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- sv/sact_scan.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Per-way evaluator: one way a cycle, accumulating hit, free way and victim candidates
module sact_scan import sact_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_start,
    input  wire logic   i_step,
    input  wire t_way   i_idx,
    input  wire t_entry i_entry,
    input  wire t_tag   i_tag,
    output t_scan       o_scan
);

    t_scan r_scan;
    t_scan n_scan;

    always_comb begin
        n_scan = r_scan;
        if (i_start) begin
            n_scan = '0;
        end else if (i_step) begin
            // first valid way with matching tag
            if (!r_scan.hit && i_entry.valid && (i_entry.tag == i_tag)) begin
                n_scan.hit     = 1'b1;
                n_scan.hit_way = i_idx;
            end
            // first invalid way
            if (!r_scan.free && !i_entry.valid) begin
                n_scan.free     = 1'b1;
                n_scan.free_way = i_idx;
            end
            // first way with counter at zero
            if (!r_scan.zero && (i_entry.cnt == '0)) begin
                n_scan.zero     = 1'b1;
                n_scan.zero_way = i_idx;
            end
            // smallest counter, lowest way wins a tie
            if ((i_idx == '0) || (i_entry.cnt < r_scan.min_cnt)) begin
                n_scan.min_cnt = i_entry.cnt;
                n_scan.min_way = i_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan <= n_scan;
    end

    assign o_scan = r_scan;

endmodule

`default_nettype wire

// ----- sv/sact_entry_upd.sv -----
`timescale 1ns / 1ps
`default_nettype none

// New state of one way after a hit or a fill
module sact_entry_upd import sact_pkg::*; (
    input  wire t_entry   i_entry,
    input  wire t_way     i_idx,
    input  wire t_upd_ctl i_ctl,
    output t_entry        o_entry
);

    logic w_tgt;
    logic w_lru_do;

    assign w_tgt    = (i_idx == i_ctl.way);
    assign w_lru_do = ((i_ctl.policy == POL_LRU) || ((i_ctl.policy == POL_FIFO) && i_ctl.fill))
                      && (i_ctl.tgt_cnt != CNT_MAX);

    always_comb begin
        o_entry = i_entry;

        // tag, valid and dirty of the touched way
        if (w_tgt) begin
            if (i_ctl.fill) begin
                o_entry.valid = 1'b1;
                o_entry.dirty = i_ctl.wr;
                o_entry.tag   = i_ctl.tag;
            end else if (i_ctl.wr) begin
                o_entry.dirty = 1'b1;
            end
        end

        // replacement counters
        unique case (i_ctl.policy)
            POL_LRU, POL_FIFO: begin
                if (w_lru_do) begin
                    if (w_tgt) begin
                        o_entry.cnt = CNT_MAX;
                    end else if (i_entry.cnt != '0) begin
                        o_entry.cnt = i_entry.cnt - t_cnt'(1);
                    end
                end
            end
            POL_RAND: begin
                if (w_tgt) begin
                    o_entry.cnt = '0;
                end
            end
            POL_LFU: begin
                if (w_tgt) begin
                    if (i_ctl.fill) begin
                        o_entry.cnt = t_cnt'(1);
                    end else if (i_entry.cnt != CNT_MAX) begin
                        o_entry.cnt = i_entry.cnt + t_cnt'(1);
                    end
                end
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/set_assoc_cache_tag_policy.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "set_assoc_cache_tag_policy_defines.svh"

// Tag, valid, dirty and replacement engine of a write-back, write-allocate
// 4-way cache with 64 sets (16-byte blocks). Each transaction on i_in is one
// access; exactly one result transaction follows on o_out with hit/way, and on
// a miss the refill address plus, for a dirty victim, the write-back address.
// Policy (LRU, FIFO, random, LFU) is set through i_cfg while no access is in
// flight; the user must keep to this, as the block itself does not enforce it.
// An accepted access has its result registered on o_out in the same cycle that
// i_in is ready again: the tag RAM is read once (S_RD, then S_LOAD), a
// single per-way evaluator then walks the ways to find the hit and victim,
// S_PICK picks the way and S_TGT reads its entry, a second walk updates the
// ways one a cycle, and the row is written back. The result waits in an output
// register while the next access proceeds, but that access holds its write-back
// cycle until the previous result is taken. Per-set row-valid flops make every
// set read as empty after reset, so there is no clearing pass.
module set_assoc_cache_tag_policy import sact_pkg::*; (
    input wire logic   i_clk,
    input wire logic   i_rst_n,
    sact_in_if.sink    i_in,
    sact_cfg_if.sink   i_cfg,
    sact_out_if.source o_out
);

    // Control state
    t_state               r_state,    n_state;
    t_policy              r_policy;
    logic [LFSR_BITS-1:0] r_lfsr,     n_lfsr;
    logic [SETS-1:0]      r_row_vld,  n_row_vld;
    logic                 r_out_valid, n_out_valid;

    // Access context and working row
    logic                 r_func,     n_func;
    logic [ADDR_BITS-1:0] r_addr,     n_addr;
    t_row                 r_row,      n_row;
    t_way                 r_idx,      n_idx;
    t_way                 r_way,      n_way;
    logic                 r_evict,    n_evict;
    t_cnt                 r_tcnt,     n_tcnt;
    logic                 r_wb,       n_wb;
    t_tag                 r_vtag,     n_vtag;

    // Result register
    logic                    r_out_hit,    n_out_hit;
    logic [OUT_WAY_BITS-1:0] r_out_way,    n_out_way;
    logic                    r_out_wb,     n_out_wb;
    logic [ADDR_BITS-1:0]    r_out_victim, n_out_victim;
    logic [ADDR_BITS-1:0]    r_out_fill,   n_out_fill;

    t_set                 w_set;
    t_tag                 w_tag;
    t_entry               w_cur;
    t_entry               w_upd;
    t_scan                w_scan;
    t_upd_ctl             w_ctl;
    logic [ROW_BITS-1:0]  w_rdata;
    logic                 w_we;
    logic                 w_scan_start;
    logic                 w_scan_step;
    logic                 w_last;
    logic                 w_lfsr_fb;

    assign w_set  = r_addr[BYTE_SEL_BITS +: SET_BITS];
    assign w_tag  = r_addr[BYTE_SEL_BITS + SET_BITS +: TAG_WIDTH];
    assign w_cur  = r_row[r_idx];
    assign w_last = (r_idx == t_way'(WAYS - 1));

    // taps 16,14,13,11
    assign w_lfsr_fb = r_lfsr[0] ^ r_lfsr[2] ^ r_lfsr[3] ^ r_lfsr[5];

    always_comb begin
        w_ctl.policy  = r_policy;
        w_ctl.fill    = !w_scan.hit;
        w_ctl.wr      = r_func;
        w_ctl.tag     = w_tag;
        w_ctl.way     = r_way;
        w_ctl.tgt_cnt = r_tcnt;
    end

    // Tag memory, one row per set
    sact_tag_ram #(
        .DEPTH (SETS),
        .WIDTH (ROW_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_set),
        .i_wdata (r_row),
        .i_raddr (w_set),
        .o_rdata (w_rdata)
    );

    sact_scan u_scan (
        .i_clk   (i_clk),
        .i_start (w_scan_start),
        .i_step  (w_scan_step),
        .i_idx   (r_idx),
        .i_entry (w_cur),
        .i_tag   (w_tag),
        .o_scan  (w_scan)
    );

    sact_entry_upd u_upd (
        .i_entry (w_cur),
        .i_idx   (r_idx),
        .i_ctl   (w_ctl),
        .o_entry (w_upd)
    );

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_lfsr       = r_lfsr;
        n_row_vld    = r_row_vld;
        n_out_valid  = r_out_valid;
        n_func       = r_func;
        n_addr       = r_addr;
        n_row        = r_row;
        n_idx        = r_idx;
        n_way        = r_way;
        n_evict      = r_evict;
        n_tcnt       = r_tcnt;
        n_wb         = r_wb;
        n_vtag       = r_vtag;
        n_out_hit    = r_out_hit;
        n_out_way    = r_out_way;
        n_out_wb     = r_out_wb;
        n_out_victim = r_out_victim;
        n_out_fill   = r_out_fill;
        w_we         = 1'b0;
        w_scan_start = 1'b0;
        w_scan_step  = 1'b0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_func  = i_in.func;
                    n_addr  = i_in.address;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                // a set never written since reset reads as empty
                n_row        = r_row_vld[w_set] ? t_row'(w_rdata) : '0;
                w_scan_start = 1'b1;
                n_idx        = '0;
                n_state      = S_SCAN;
            end
            S_SCAN: begin
                w_scan_step = 1'b1;
                n_idx       = r_idx + t_way'(1);
                if (w_last) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                n_evict = 1'b0;
                if (w_scan.hit) begin
                    n_way = w_scan.hit_way;
                end else if (w_scan.free) begin
                    n_way = w_scan.free_way;
                end else begin
                    n_evict = 1'b1;
                    unique case (r_policy)
                        POL_RAND: begin
                            n_way  = r_lfsr[WAY_BITS-1:0];
                            n_lfsr = {w_lfsr_fb, r_lfsr[LFSR_BITS-1:1]};
                        end
                        POL_LFU: begin
                            n_way = w_scan.min_way;
                        end
                        POL_LRU, POL_FIFO: begin
                            n_way = w_scan.zero ? w_scan.zero_way : '0;
                        end
                    endcase
                end
                n_idx   = n_way;
                n_state = S_TGT;
            end
            S_TGT: begin
                // target entry before any update
                n_tcnt  = w_cur.cnt;
                n_wb    = r_evict && w_cur.dirty;
                n_vtag  = w_cur.tag;
                n_idx   = '0;
                n_state = S_APPLY;
            end
            S_APPLY: begin
                n_row[r_idx] = w_upd;
                n_idx        = r_idx + t_way'(1);
                if (w_last) begin
                    n_state = S_WR;
                end
            end
            S_WR: begin
                if (!r_out_valid || o_out.ready) begin
                    w_we             = 1'b1;
                    n_row_vld[w_set] = 1'b1;
                    n_out_valid      = 1'b1;
                    n_out_hit        = w_scan.hit;
                    n_out_way        = OUT_WAY_BITS'(r_way);
                    n_out_wb         = r_wb;
                    n_out_victim     = r_wb ? {r_vtag, w_set, {BYTE_SEL_BITS{1'b0}}} : '0;
                    n_out_fill       = w_scan.hit ? '0
                                     : {r_addr[ADDR_BITS-1:BYTE_SEL_BITS],
                                        {BYTE_SEL_BITS{1'b0}}};
                    n_state          = S_IDLE;
                end
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lfsr      <= LFSR_BITS'(1);
            r_row_vld   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lfsr      <= n_lfsr;
            r_row_vld   <= n_row_vld;
            r_out_valid <= n_out_valid;
        end
    end

    // Policy register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= POL_LRU;
        end else if (i_cfg.valid) begin
            r_policy <= t_policy'(i_cfg.policy);
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_func       <= n_func;
        r_addr       <= n_addr;
        r_row        <= n_row;
        r_idx        <= n_idx;
        r_way        <= n_way;
        r_evict      <= n_evict;
        r_tcnt       <= n_tcnt;
        r_wb         <= n_wb;
        r_vtag       <= n_vtag;
        r_out_hit    <= n_out_hit;
        r_out_way    <= n_out_way;
        r_out_wb     <= n_out_wb;
        r_out_victim <= n_out_victim;
        r_out_fill   <= n_out_fill;
    end

    // Ports
    assign i_in.ready          = (r_state == S_IDLE);
    assign i_cfg.ready         = 1'b1;
    assign o_out.valid         = r_out_valid;
    assign o_out.hit           = r_out_hit;
    assign o_out.way           = r_out_way;
    assign o_out.writeback     = r_out_wb;
    assign o_out.evict_address = r_out_victim;
    assign o_out.fill_address  = r_out_fill;

    // Checks
    `SACT_ASSERT(a_accept_reads, (i_in.valid && i_in.ready) |=> (r_state == S_RD), "accepted transaction did not start a tag read")
    `SACT_ASSERT(a_hit_no_wb, o_out.valid |-> !(o_out.hit && o_out.writeback), "write-back reported on a hit")
    `SACT_ASSERT(a_hit_no_fill, (o_out.valid && o_out.hit) |-> (o_out.fill_address == '0), "refill address on a hit")
    `SACT_ASSERT(a_victim_zero, (o_out.valid && !o_out.writeback) |-> (o_out.evict_address == '0), "victim address without write-back")
    `SACT_ASSERT_ALWAYS(a_ram_write_state, w_we |-> (r_state == S_WR), "tag RAM written outside write-back state")

endmodule

`default_nettype wire

// ----- verif/set_assoc_cache_tag_policy_tb.sv -----
`timescale 1ns / 1ps

module set_assoc_cache_tag_policy_tb;
    import sact_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int MAX_REPORTS    = 10;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 110;

    // One result transaction as seen on o_out
    typedef struct packed {
        logic                    hit;
        logic [OUT_WAY_BITS-1:0] way;
        logic                    writeback;
        logic [ADDR_BITS-1:0]    evict_address;
        logic [ADDR_BITS-1:0]    fill_address;
    } t_lookup_result;

    // Mirror of the tag/valid/dirty/counter stores plus the queue of lookup
    // results still owed by the block.
    class tag_policy_tracker;
        t_tag                 tags   [SETS][WAYS];
        bit                   valids [SETS][WAYS];
        bit                   dirtys [SETS][WAYS];
        t_cnt                 counts [SETS][WAYS];
        logic [LFSR_BITS-1:0] lfsr;
        t_policy              policy;
        t_lookup_result       pending_lookups[$];
        int mismatches, stray_results, reports;
        int hits, misses, writebacks;
        int per_policy[4];

        function new();
            for (int s = 0; s < SETS; s++) begin
                for (int w = 0; w < WAYS; w++) begin
                    tags[s][w]   = '0;
                    valids[s][w] = 1'b0;
                    dirtys[s][w] = 1'b0;
                    counts[s][w] = '0;
                end
            end
            lfsr   = 16'h0001;
            policy = POL_LRU;
        endfunction

        function void set_policy(t_policy p);
            policy = p;
        endfunction

        function int pending();
            return pending_lookups.size();
        endfunction

        // Most-recent way goes to max, other live counters age by one
        function void bump_recency(int s, t_way w);
            if (counts[s][w] == CNT_MAX) return;
            for (int i = 0; i < WAYS; i++) begin
                if (i != w && counts[s][i] != 0) counts[s][i]--;
            end
            counts[s][w] = CNT_MAX;
        endfunction

        function void update_counters(int s, t_way w, bit fill);
            case (policy)
                POL_LRU:  bump_recency(s, w);
                POL_FIFO: if (fill) bump_recency(s, w);
                POL_RAND: counts[s][w] = '0;
                default: begin
                    if (fill) counts[s][w] = '0;
                    if (counts[s][w] != CNT_MAX) counts[s][w]++;
                end
            endcase
        endfunction

        function t_way pick_victim(int s);
            t_way v;
            t_cnt least;
            v = '0;
            case (policy)
                POL_RAND: begin
                    v    = t_way'(lfsr % WAYS);
                    lfsr = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[LFSR_BITS-1:1]};
                end
                POL_LFU: begin
                    least = counts[s][0];
                    for (int i = 1; i < WAYS; i++) begin
                        if (counts[s][i] < least) begin
                            least = counts[s][i];
                            v     = t_way'(i);
                        end
                    end
                end
                default: begin
                    // lowest zero counter; way 0 when none is zero
                    for (int i = WAYS - 1; i >= 0; i--) begin
                        if (counts[s][i] == 0) v = t_way'(i);
                    end
                end
            endcase
            return v;
        endfunction

        // Predict the lookup for one accepted access and update the mirror
        function void note_access(logic is_write, logic [ADDR_BITS-1:0] addr);
            t_lookup_result r;
            int             s;
            t_tag           tg;
            bit             found;
            t_way           w;
            s     = addr[BYTE_SEL_BITS +: SET_BITS];
            tg    = addr[ADDR_BITS-1 -: TAG_WIDTH];
            r     = '0;
            found = 1'b0;
            w     = '0;
            per_policy[policy]++;
            for (int i = WAYS - 1; i >= 0; i--) begin
                if (valids[s][i] && tags[s][i] == tg) begin
                    found = 1'b1;
                    w     = t_way'(i);
                end
            end
            if (found) begin
                r.hit = 1'b1;
                if (is_write) dirtys[s][w] = 1'b1;
                update_counters(s, w, 1'b0);
                hits++;
            end else begin
                for (int i = WAYS - 1; i >= 0; i--) begin
                    if (!valids[s][i]) begin
                        found = 1'b1;
                        w     = t_way'(i);
                    end
                end
                if (!found) begin
                    w = pick_victim(s);
                    if (dirtys[s][w]) begin
                        r.writeback     = 1'b1;
                        r.evict_address = {tags[s][w], t_set'(s), {BYTE_SEL_BITS{1'b0}}};
                        writebacks++;
                    end
                end
                r.fill_address = {addr[ADDR_BITS-1:BYTE_SEL_BITS], {BYTE_SEL_BITS{1'b0}}};
                valids[s][w] = 1'b1;
                dirtys[s][w] = is_write;
                tags[s][w]   = tg;
                update_counters(s, w, 1'b1);
                misses++;
            end
            r.way = OUT_WAY_BITS'(w);
            pending_lookups = {pending_lookups, r};
        endfunction

        function void check_result(t_lookup_result got);
            t_lookup_result want;
            if (pending_lookups.size() == 0) begin
                stray_results++;
                if (reports < MAX_REPORTS) begin
                    reports++;
                    $display("%0t: result with nothing pending: %p", $realtime, got);
                end
                return;
            end
            want = pending_lookups.pop_front();
            if (got.hit !== want.hit || got.way !== want.way ||
                got.writeback !== want.writeback ||
                got.evict_address !== want.evict_address ||
                got.fill_address !== want.fill_address) begin
                mismatches++;
                if (reports < MAX_REPORTS) begin
                    reports++;
                    $display("%0t: mismatch (exp/act) hit %b/%b way %0d/%0d wb %b/%b",
                             $realtime, want.hit, got.hit, want.way, got.way,
                             want.writeback, got.writeback);
                    $display("    victim %h/%h fill %h/%h",
                             want.evict_address, got.evict_address,
                             want.fill_address, got.fill_address);
                end
            end
        endfunction

        function int failures();
            return mismatches + stray_results + pending_lookups.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    sact_in_if  in_if ();
    sact_out_if out_if ();
    sact_cfg_if cfg_if ();

    set_assoc_cache_tag_policy u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    tag_policy_tracker tracker = new();

    bit   snd_burst;
    bit   rcv_burst;
    int   rcv_stall;
    int   idle_cycles;
    t_set hot_sets [4];
    t_tag hot_tags [6];

    always #10 i_clk = ~i_clk;

    // Result side: ready follows a per-transaction stall count
    always @(negedge i_clk) begin
        if (rcv_stall > 0) begin
            out_if.ready = 1'b0;
            rcv_stall--;
        end else begin
            out_if.ready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            tracker.check_result({out_if.hit, out_if.way, out_if.writeback,
                                  out_if.evict_address, out_if.fill_address});
            if ($urandom_range(0, 29) == 0) rcv_burst = ~rcv_burst;
            rcv_stall = rcv_burst ? 0 : $urandom_range(0, 18);
        end
    end

    // Watchdog: cycles without any transaction on any channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
                (cfg_if.valid && cfg_if.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $realtime, idle_cycles);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic send_access(logic is_write, logic [ADDR_BITS-1:0] addr);
        int gap;
        if ($urandom_range(0, 29) == 0) snd_burst = ~snd_burst;
        gap = snd_burst ? 0 : $urandom_range(0, 18);
        @(negedge i_clk);
        if (gap > 0) begin
            in_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid   = 1'b1;
        in_if.func    = is_write;
        in_if.address = addr;
        do @(posedge i_clk); while (!in_if.ready);
        tracker.note_access(is_write, addr);
    endtask

    // Hold the access channel idle until every owed result has come back
    task automatic drain_pipeline();
        @(negedge i_clk);
        in_if.valid = 1'b0;
        while (tracker.pending() > 0) @(negedge i_clk);
    endtask

    task automatic write_policy(t_policy p);
        drain_pipeline();
        @(negedge i_clk);
        cfg_if.valid  = 1'b1;
        cfg_if.policy = p;
        do @(posedge i_clk); while (!cfg_if.ready);
        tracker.set_policy(p);
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    initial begin
        t_policy p;
        int      roll;
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        in_if.valid   = 1'b0;
        in_if.func    = 1'b0;
        in_if.address = '0;
        cfg_if.valid  = 1'b0;
        cfg_if.policy = POL_LRU;
        out_if.ready  = 1'b0;
        rcv_stall     = 0;
        idle_cycles   = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // LRU: address corners, write hit, dirty eviction from a full set 0
        send_access(1'b0, 32'h0000_0000);
        send_access(1'b1, 32'hFFFF_FFFF);
        send_access(1'b0, 32'hFFFF_FFF0);
        send_access(1'b1, 32'h0000_000F);
        send_access(1'b1, 32'h0000_0400);
        send_access(1'b1, 32'h0000_0800);
        send_access(1'b1, 32'h0000_0C00);
        send_access(1'b0, 32'h0000_1000);
        // FIFO: a hit leaves counters alone, then an eviction
        write_policy(POL_FIFO);
        send_access(1'b0, 32'h0000_0800);
        send_access(1'b1, 32'h0000_1400);
        // random victims in the full set
        write_policy(POL_RAND);
        send_access(1'b0, 32'h0000_1800);
        send_access(1'b1, 32'h0000_1C00);
        // LFU: fill set 1 and saturate every counter
        write_policy(POL_LFU);
        for (int t = 0; t < 4; t++) send_access(t[0], ((t + 8) << 10) | 32'h10);
        for (int r = 0; r < 2; r++) begin
            for (int t = 0; t < 4; t++) send_access(1'b0, ((t + 8) << 10) | 32'h10);
        end
        // back to LRU with no zero counter left: victim falls to way 0
        write_policy(POL_LRU);
        send_access(1'b0, 32'h0001_0010);

        // Random phases: hot sets and tags so hits and evictions are frequent
        for (int ph = 0; ph < PHASES; ph++) begin
            p = (ph < 4) ? t_policy'(ph) : t_policy'($urandom_range(0, 3));
            write_policy(p);
            if (ph % 2 == 0) begin
                foreach (hot_sets[i]) hot_sets[i] = t_set'($urandom_range(0, SETS - 1));
            end
            foreach (hot_tags[i]) begin
                if ($urandom_range(0, 1) == 0) hot_tags[i] = t_tag'($urandom);
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < 2) drain_pipeline();
                if (roll < 85) begin
                    send_access(1'($urandom), {hot_tags[$urandom_range(0, 5)],
                                               hot_sets[$urandom_range(0, 3)],
                                               BYTE_SEL_BITS'($urandom)});
                end else begin
                    send_access(1'($urandom), $urandom);
                end
            end
        end

        drain_pipeline();
        repeat (20) @(posedge i_clk);

        $display("Covered %0d accesses: %0d hits, %0d misses, %0d dirty evictions",
                 tracker.hits + tracker.misses, tracker.hits, tracker.misses,
                 tracker.writebacks);
        $display("Accesses per policy LRU/FIFO/random/LFU: %0d/%0d/%0d/%0d, %0d failures",
                 tracker.per_policy[POL_LRU], tracker.per_policy[POL_FIFO],
                 tracker.per_policy[POL_RAND], tracker.per_policy[POL_LFU],
                 tracker.failures());
        if (tracker.failures() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
